// ----- sv/dcem_pkg.sv -----
`timescale 1ns / 1ps
// dcem_pkg: shared types, register codes and divider constants for the
// debounced cliff and encoder monitor. No dependencies.
package dcem_pkg;

  localparam int unsigned SENSOR_W = 8;
  localparam int unsigned TARGET_W = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned MAG_W    = TARGET_W + 1;

  // Millimetres per encoder edge, valid range 1..256.
  localparam int unsigned MM_PER_EDGE = 4;

  // Exact divide of a MAG_W-bit magnitude by reciprocal multiply:
  // q = (mag * ceil(2^(MAG_W+l) / d)) >> (MAG_W+l), l = ceil(log2 d).
  localparam int unsigned DIV_SHIFT = MAG_W + $clog2(MM_PER_EDGE);
  localparam int unsigned RECIP_W   = MAG_W + 1;
  localparam int unsigned PROD_W    = MAG_W + RECIP_W;
  localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + MM_PER_EDGE - 1) / MM_PER_EDGE;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_TARGET = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_CLIFF_EN    = 2'd0,
    REG_CLIFF_MASK  = 2'd1,
    REG_LEFT_MASK   = 2'd2,
    REG_RIGHT_MASK  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                cliff_enable;
    logic [SENSOR_W-1:0] cliff_bit_mask;
    logic [SENSOR_W-1:0] left_encoder_mask;
    logic [SENSOR_W-1:0] right_encoder_mask;
  } cfg_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SENSOR_W-1:0] raw_bits;
    logic                motors_idle;
    logic [TARGET_W-1:0] target_mm;
  } item_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] stable_bits;
    logic                cliff_stop;
    logic                distance_done;
  } res_t;

endpackage

// ----- sv/dcem_if.sv -----
`timescale 1ns / 1ps
// dcem_item_if / dcem_result_if: valid/ready channels for input and result words.
// Depends on dcem_pkg.
interface dcem_item_if import dcem_pkg::*;;
  logic                       valid;
  logic                       ready;
  opcode_t                    opcode;
  logic [SENSOR_W-1:0]        raw_bits;
  logic                       motors_idle;
  logic signed [TARGET_W-1:0] target_mm;

  modport source (output valid, opcode, raw_bits, motors_idle, target_mm, input ready);
  modport sink   (input valid, opcode, raw_bits, motors_idle, target_mm, output ready);
endinterface

interface dcem_result_if import dcem_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] stable_bits;
  logic                cliff_stop;
  logic                distance_done;

  modport source (output valid, stable_bits, cliff_stop, distance_done, input ready);
  modport sink   (input valid, stable_bits, cliff_stop, distance_done, output ready);
endinterface

// ----- sv/dcem_cfg.sv -----
`timescale 1ns / 1ps
// dcem_cfg: APB register file for the cliff enable and the three bit masks.
// Depends on dcem_pkg.
module dcem_cfg import dcem_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cliff_enable       <= 1'b1;
      cfg.cliff_bit_mask     <= SENSOR_W'(1);
      cfg.left_encoder_mask  <= SENSOR_W'(2);
      cfg.right_encoder_mask <= SENSOR_W'(4);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CLIFF_EN:   cfg.cliff_enable       <= pwdata[0];
        REG_CLIFF_MASK: cfg.cliff_bit_mask     <= pwdata[SENSOR_W-1:0];
        REG_LEFT_MASK:  cfg.left_encoder_mask  <= pwdata[SENSOR_W-1:0];
        REG_RIGHT_MASK: cfg.right_encoder_mask <= pwdata[SENSOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CLIFF_EN:   prdata = APB_DW'(cfg.cliff_enable);
      REG_CLIFF_MASK: prdata = APB_DW'(cfg.cliff_bit_mask);
      REG_LEFT_MASK:  prdata = APB_DW'(cfg.left_encoder_mask);
      REG_RIGHT_MASK: prdata = APB_DW'(cfg.right_encoder_mask);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- sv/dcem_core.sv -----
`timescale 1ns / 1ps
// dcem_core: debounce, cliff check, target load and edge countdown state.
// Depends on dcem_pkg.
module dcem_core import dcem_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [SENSOR_W-1:0] previous_raw, stable_value, encoder_previous;
  logic [CNT_W-1:0]    pending_edges, left_edges_left, right_edges_left;

  logic [SENSOR_W-1:0] previous_raw_next, stable_value_next, encoder_previous_next;
  logic [CNT_W-1:0]    pending_edges_next, left_edges_left_next, right_edges_left_next;

  logic [SENSOR_W-1:0] disagree, edge_bits;
  logic                is_tick, running, cliff, load, active, done;
  logic [CNT_W-1:0]    left_base, right_base;
  logic [SENSOR_W-1:0] enc_base;
  logic [MAG_W-1:0]    tgt_ext, magnitude;
  logic [PROD_W-1:0]   product;
  logic [CNT_W-1:0]    quotient;

  // |target| / MM_PER_EDGE via reciprocal multiply
  assign tgt_ext   = {item.target_mm[TARGET_W-1], item.target_mm};
  assign magnitude = item.target_mm[TARGET_W-1] ? (~tgt_ext + MAG_W'(1)) : tgt_ext;
  assign product   = PROD_W'(magnitude) * PROD_W'(RECIP_W'(DIV_RECIP));
  assign quotient  = CNT_W'(product >> DIV_SHIFT);

  assign is_tick  = (item.opcode == OP_TICK);
  assign disagree = previous_raw ^ item.raw_bits;
  assign stable_value_next = is_tick ?
      ((stable_value & disagree) | (item.raw_bits & ~disagree)) : stable_value;
  assign previous_raw_next = is_tick ? item.raw_bits : previous_raw;

  assign running = is_tick && !item.motors_idle;
  assign cliff   = running && cfg.cliff_enable && |(stable_value_next & cfg.cliff_bit_mask);
  assign load    = running && !cliff && (pending_edges != '0);

  assign left_base  = load ? pending_edges : left_edges_left;
  assign right_base = load ? pending_edges : right_edges_left;
  assign enc_base   = load ? stable_value_next : encoder_previous;
  assign active     = running && !cliff && ((left_base != '0) || (right_base != '0));
  assign edge_bits  = stable_value_next ^ enc_base;

  always_comb begin
    left_edges_left_next  = left_edges_left;
    right_edges_left_next = right_edges_left;
    if (cliff) begin
      left_edges_left_next  = '0;
      right_edges_left_next = '0;
    end else if (active) begin
      left_edges_left_next  = left_base;
      right_edges_left_next = right_base;
      if (|(edge_bits & cfg.left_encoder_mask) && (left_base != '0))
        left_edges_left_next = left_base - CNT_W'(1);
      if (|(edge_bits & cfg.right_encoder_mask) && (right_base != '0))
        right_edges_left_next = right_base - CNT_W'(1);
    end
  end

  assign encoder_previous_next = active ? stable_value_next : encoder_previous;
  assign done = active && (left_edges_left_next == '0) && (right_edges_left_next == '0);

  always_comb begin
    priority if (!is_tick)    pending_edges_next = quotient;
    else if (cliff || load)   pending_edges_next = '0;
    else                      pending_edges_next = pending_edges;
  end

  assign res.stable_bits   = stable_value_next;
  assign res.cliff_stop    = cliff;
  assign res.distance_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw     <= '0;
      stable_value     <= '0;
      encoder_previous <= '0;
      pending_edges    <= '0;
      left_edges_left  <= '0;
      right_edges_left <= '0;
    end else if (fire) begin
      previous_raw     <= previous_raw_next;
      stable_value     <= stable_value_next;
      encoder_previous <= encoder_previous_next;
      pending_edges    <= pending_edges_next;
      left_edges_left  <= left_edges_left_next;
      right_edges_left <= right_edges_left_next;
    end
  end

  a_cliff_clears: assert property (@(posedge clk) disable iff (rst)
      fire && res.cliff_stop |=>
      (left_edges_left == '0) && (right_edges_left == '0) && (pending_edges == '0))
    else $error("cliff stop left counts behind");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
      fire && res.distance_done |=> (left_edges_left == '0) && (right_edges_left == '0))
    else $error("distance done with edges remaining");

  a_target_keeps: assert property (@(posedge clk) disable iff (rst)
      fire && (item.opcode == OP_TARGET) |=>
      $stable(stable_value) && $stable(left_edges_left) && $stable(right_edges_left))
    else $error("set target disturbed tick state");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      !fire |=> $stable(pending_edges) && $stable(left_edges_left) && $stable(stable_value))
    else $error("state moved without a word");

  a_excl: assert property (@(posedge clk) disable iff (rst)
      fire |-> !(res.cliff_stop && res.distance_done))
    else $error("cliff stop and distance done together");

endmodule

// ----- sv/debounced_cliff_and_encoder_monitor_top.sv -----
`timescale 1ns / 1ps
// An accepted word goes from the input register through dcem_core to the result register.
// One word per cycle while rsp.ready is high; input and result registers each hold one word.
// The state update and result come from one pass of logic in dcem_core per word.
// Reset (rst, synchronous, active high): channels empty, all state zero, registers at defaults.
// Top level: input register, dcem_core, result register and the dcem_cfg APB port.
module debounced_cliff_and_encoder_monitor_top import dcem_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  dcem_item_if.sink          req,
  dcem_result_if.source      rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  res_t  res;
  res_t  out_res;
  logic  out_valid;
  logic  advance;

  // Register file
  dcem_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1 word moves on when the result register is free or being drained.
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.opcode      <= req.opcode;
      s1_item.raw_bits    <= req.raw_bits;
      s1_item.motors_idle <= req.motors_idle;
      s1_item.target_mm   <= req.target_mm;
    end
  end

  // Single pass: debounce, cliff, load, count; state commits on advance.
  dcem_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.stable_bits   = out_res.stable_bits;
  assign rsp.cliff_stop    = out_res.cliff_stop;
  assign rsp.distance_done = out_res.distance_done;

endmodule
